FILE: rtl/core/srfp_pkg.sv
`default_nettype none
package srfp_pkg;

  localparam int unsigned FRAME_CAP = 8;
  localparam int unsigned IDX_W     = 4;

  localparam logic [7:0] FRAME_HEADER    = 8'hAA;
  localparam logic [7:0] TEMP_FRAME_LEN  = 8'h06;
  localparam logic [7:0] PRESS_FRAME_LEN = 8'h08;
  localparam logic [7:0] TEMP_TYPE_CODE  = 8'h0A;
  localparam logic [7:0] PRESS_TYPE_CODE = 8'h09;

  // bytes 0..4 go into the running sum
  localparam logic [IDX_W-1:0] SUM_SPAN  = 4'd5;
  localparam logic [IDX_W-1:0] CAP_LIMIT = 4'd8;

  localparam logic [1:0] CMD_TEMP  = 2'd0;
  localparam logic [1:0] CMD_PRESS = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_BADFIELD = 3'd2;
  localparam logic [2:0] ST_BADSUM   = 3'd3;
  localparam logic [2:0] ST_NOTEMP   = 3'd4;

  typedef struct packed {
    logic                      header_seen;
    logic [IDX_W-1:0]          byte_index;
    logic [7:0]                running_sum;
    logic [FRAME_CAP-1:0][7:0] bytes;
  } frame_view_t;

endpackage
`default_nettype wire

FILE: rtl/core/srfp_capture.sv
`default_nettype none
module srfp_capture (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cap_en,
  input  wire logic                 restart,
  input  wire logic [7:0]           data_byte,
  output srfp_pkg::frame_view_t     view_nxt
);

  logic                              header_seen_r;
  logic [srfp_pkg::IDX_W-1:0]        byte_index_r;
  logic [7:0]                        running_sum_r;
  logic [srfp_pkg::FRAME_CAP-1:0][7:0] bytes_r;

  // frame as it stands once the current byte is taken in
  always_comb begin
    view_nxt.header_seen = header_seen_r;
    view_nxt.byte_index  = byte_index_r;
    view_nxt.running_sum = running_sum_r;
    view_nxt.bytes       = bytes_r;
    if (!header_seen_r) begin
      if (data_byte == srfp_pkg::FRAME_HEADER) begin
        view_nxt.header_seen = 1'b1;
        view_nxt.bytes[0]    = data_byte;
        view_nxt.byte_index  = 4'd1;
        view_nxt.running_sum = data_byte;
      end
    end else if (byte_index_r < srfp_pkg::CAP_LIMIT) begin
      view_nxt.bytes[byte_index_r[2:0]] = data_byte;
      if (byte_index_r < srfp_pkg::SUM_SPAN) begin
        view_nxt.running_sum = running_sum_r + data_byte;
      end
      view_nxt.byte_index = byte_index_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_seen_r <= 1'b0;
      byte_index_r  <= '0;
      running_sum_r <= '0;
    end else if (restart) begin
      header_seen_r <= 1'b0;
      byte_index_r  <= '0;
      running_sum_r <= '0;
    end else if (cap_en) begin
      header_seen_r <= view_nxt.header_seen;
      byte_index_r  <= view_nxt.byte_index;
      running_sum_r <= view_nxt.running_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_en) begin
      bytes_r <= view_nxt.bytes;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/srfp_check.sv
`default_nettype none
module srfp_check (
  input  wire logic                  kind,
  input  wire srfp_pkg::frame_view_t view,
  input  wire logic                  temp_zero,
  output logic [2:0]                 status
);

  logic [7:0] exp_len;
  logic [7:0] exp_type;
  logic [7:0] sum_byte;
  logic [7:0] frame_sum;

  always_comb begin
    exp_len   = kind ? srfp_pkg::PRESS_FRAME_LEN : srfp_pkg::TEMP_FRAME_LEN;
    exp_type  = kind ? srfp_pkg::PRESS_TYPE_CODE : srfp_pkg::TEMP_TYPE_CODE;
    sum_byte  = kind ? view.bytes[7] : view.bytes[5];
    frame_sum = kind ? (view.running_sum + view.bytes[5] + view.bytes[6])
                     : view.running_sum;
    if (kind && temp_zero) begin
      status = srfp_pkg::ST_NOTEMP;
    end else if (!view.header_seen || ({4'd0, view.byte_index} < exp_len)) begin
      status = srfp_pkg::ST_SHORT;
    end else if ((view.bytes[1] != exp_len) || (view.bytes[2] != exp_type)) begin
      status = srfp_pkg::ST_BADFIELD;
    end else if (frame_sum != sum_byte) begin
      status = srfp_pkg::ST_BADSUM;
    end else begin
      status = srfp_pkg::ST_OK;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sensor_reply_frame_parser.sv
// an accepted item passes through the input register, then the result register
// throughput: one item per cycle unless in_stall is raised; the result register holds a stalled
// result while the input register takes the next item
// reset: synchronous active-low rst_n clears the frame hunt, held values, valid mark,
// kind, frame count and both valid flags; captured frame bytes are not reset
`default_nettype none
module sensor_reply_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic             out_reply_kind,
  output logic             out_value_valid,
  output logic [15:0]      out_temperature_tenths,
  output logic [31:0]      out_pressure_raw,
  output logic [31:0]      out_good_frames
);

  logic       stg_valid_r;
  logic [1:0] stg_cmd_r;
  logic [7:0] stg_byte_r;
  logic       stg_last_r;

  logic [15:0] temp_held_r;
  logic [31:0] press_held_r;
  logic [31:0] frame_cnt_r;
  logic        valid_mark_r;
  logic        last_kind_r;

  logic [15:0] temp_held_nxt;
  logic [31:0] press_held_nxt;
  logic [31:0] frame_cnt_nxt;
  logic        valid_mark_nxt;
  logic        last_kind_nxt;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic        out_kind_r;
  logic        out_vmark_r;
  logic [15:0] out_temp_r;
  logic [31:0] out_press_r;
  logic [31:0] out_cnt_r;

  logic       advance;
  logic       accept;
  logic       commit;
  logic       is_byte;
  logic       is_clear;
  logic       cap_en;
  logic       restart;
  logic       eval;
  logic       good;
  logic [2:0] status;

  srfp_pkg::frame_view_t view_nxt;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = stg_valid_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign commit   = stg_valid_r && advance;

  assign is_byte  = (stg_cmd_r == srfp_pkg::CMD_TEMP) || (stg_cmd_r == srfp_pkg::CMD_PRESS);
  assign is_clear = (stg_cmd_r == srfp_pkg::CMD_CLEAR);
  assign cap_en   = commit && is_byte;
  assign eval     = cap_en && stg_last_r;
  assign restart  = (commit && is_clear) || eval;
  assign good     = eval && (status == srfp_pkg::ST_OK);

  srfp_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap_en    (cap_en),
    .restart   (restart),
    .data_byte (stg_byte_r),
    .view_nxt  (view_nxt)
  );

  srfp_check u_check (
    .kind      (stg_cmd_r[0]),
    .view      (view_nxt),
    .temp_zero (temp_held_r == 16'd0),
    .status    (status)
  );

  always_comb begin
    temp_held_nxt  = temp_held_r;
    press_held_nxt = press_held_r;
    frame_cnt_nxt  = frame_cnt_r;
    valid_mark_nxt = valid_mark_r;
    last_kind_nxt  = last_kind_r;
    if (commit && is_clear) begin
      temp_held_nxt  = '0;
      press_held_nxt = '0;
      valid_mark_nxt = 1'b0;
      last_kind_nxt  = 1'b0;
    end else if (good) begin
      if (stg_cmd_r[0]) begin
        // pressure is little-endian in bytes 3..6
        press_held_nxt = {view_nxt.bytes[6], view_nxt.bytes[5],
                          view_nxt.bytes[4], view_nxt.bytes[3]};
      end else begin
        temp_held_nxt = {view_nxt.bytes[3], view_nxt.bytes[4]};
      end
      last_kind_nxt  = stg_cmd_r[0];
      valid_mark_nxt = 1'b1;
      frame_cnt_nxt  = frame_cnt_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r  <= 1'b0;
      temp_held_r  <= '0;
      press_held_r <= '0;
      frame_cnt_r  <= '0;
      valid_mark_r <= 1'b0;
      last_kind_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        stg_valid_r <= 1'b1;
      end else if (advance) begin
        stg_valid_r <= 1'b0;
      end
      temp_held_r  <= temp_held_nxt;
      press_held_r <= press_held_nxt;
      frame_cnt_r  <= frame_cnt_nxt;
      valid_mark_r <= valid_mark_nxt;
      last_kind_r  <= last_kind_nxt;
      if (eval) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_cmd_r  <= in_command;
      stg_byte_r <= in_data_byte;
      stg_last_r <= in_last_byte;
    end
    if (eval) begin
      out_status_r <= status;
      out_kind_r   <= last_kind_nxt;
      out_vmark_r  <= valid_mark_nxt;
      out_temp_r   <= temp_held_nxt;
      out_press_r  <= press_held_nxt;
      out_cnt_r    <= frame_cnt_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_reply_kind         = out_kind_r;
  assign out_value_valid        = out_vmark_r;
  assign out_temperature_tenths = out_temp_r;
  assign out_pressure_raw       = out_press_r;
  assign out_good_frames        = out_cnt_r;

`ifndef NO_ASSERTIONS
  a_ok_sets_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == srfp_pkg::ST_OK) |-> out_value_valid)
    else $error("good reply without valid mark");

  a_kind_needs_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_value_valid |-> !out_reply_kind)
    else $error("pressure kind held without a good reply");

  a_press_has_temp : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == srfp_pkg::ST_OK) && out_reply_kind
      |-> (out_temperature_tenths != 16'd0))
    else $error("pressure accepted with no temperature held");

  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    good |=> (frame_cnt_r == $past(frame_cnt_r) + 32'd1))
    else $error("good frame count did not advance");

  a_stall_only_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stg_valid_r && out_valid_r)
    else $error("input stalled with room to take an item");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1350;

  typedef struct packed {
    logic [2:0]  status;
    logic        kind;
    logic        value_ok;
    logic [15:0] temp;
    logic [31:0] press;
    logic [31:0] count;
  } reply_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    logic       is_last;
    logic       typed;
    reply_t     want;
  } stim_t;

  localparam reply_t NO_REPLY = '0;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = srfp_pkg::CMD_TEMP;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic        out_reply_kind;
  logic        out_value_valid;
  logic [15:0] out_temperature_tenths;
  logic [31:0] out_pressure_raw;
  logic [31:0] out_good_frames;

  sensor_reply_frame_parser dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_command             (in_command),
    .in_data_byte           (in_data_byte),
    .in_last_byte           (in_last_byte),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_reply_kind         (out_reply_kind),
    .out_value_valid        (out_value_valid),
    .out_temperature_tenths (out_temperature_tenths),
    .out_pressure_raw       (out_pressure_raw),
    .out_good_frames        (out_good_frames)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // parser state as predicted
  logic        hunt_on = 1'b0;
  logic [3:0]  cap_count = '0;
  logic [7:0]  cap_bytes [8];
  logic [7:0]  part_sum = '0;
  logic [15:0] temp_hold = '0;
  logic [31:0] press_hold = '0;
  logic [31:0] good_count = '0;
  logic        held_valid = 1'b0;
  logic        held_kind = 1'b0;

  stim_t  stim_q [$];
  stim_t  dir_rows [26];
  reply_t reply_q [$];
  int     random_fed = 0;
  int     took_idx = 0;
  int     send_idx = 0;
  int     gap_left = 0;
  int     burst_left = 0;
  int     stall_run = 0;
  int     stall_mode = 0;
  int     mismatch_count = 0;

  task automatic predict_reply(input logic [1:0] cmd, input logic [7:0] b,
                               input logic is_last, output bit made, output reply_t r);
    logic [7:0] flen;
    logic [7:0] ftype;
    logic [7:0] chk;
    logic [2:0] st;
    logic       kind;
    made = 1'b0;
    r = NO_REPLY;
    if (cmd == CMD_UNUSED) return;
    if (cmd == srfp_pkg::CMD_CLEAR) begin
      hunt_on = 1'b0;
      cap_count = '0;
      part_sum = '0;
      temp_hold = '0;
      press_hold = '0;
      held_valid = 1'b0;
      held_kind = 1'b0;
      return;
    end
    if (!hunt_on) begin
      if (b == srfp_pkg::FRAME_HEADER) begin
        hunt_on = 1'b1;
        cap_bytes[0] = b;
        cap_count = 4'd1;
        part_sum = b;
      end
    end else if (cap_count < srfp_pkg::CAP_LIMIT) begin
      cap_bytes[cap_count[2:0]] = b;
      if (cap_count < srfp_pkg::SUM_SPAN) part_sum = part_sum + b;
      cap_count = cap_count + 4'd1;
    end
    if (!is_last) return;

    kind = (cmd == srfp_pkg::CMD_PRESS);
    flen = kind ? srfp_pkg::PRESS_FRAME_LEN : srfp_pkg::TEMP_FRAME_LEN;
    ftype = kind ? srfp_pkg::PRESS_TYPE_CODE : srfp_pkg::TEMP_TYPE_CODE;
    // pressure is refused before any frame check while no temperature is held
    if (kind && temp_hold == 16'h0000) begin
      st = srfp_pkg::ST_NOTEMP;
    end else if (!hunt_on || cap_count < flen) begin
      st = srfp_pkg::ST_SHORT;
    end else if (cap_bytes[1] != flen || cap_bytes[2] != ftype) begin
      st = srfp_pkg::ST_BADFIELD;
    end else begin
      chk = part_sum;
      if (kind) chk = chk + cap_bytes[5] + cap_bytes[6];
      st = (chk == cap_bytes[3'(flen - 8'd1)]) ? srfp_pkg::ST_OK : srfp_pkg::ST_BADSUM;
    end
    if (st == srfp_pkg::ST_OK) begin
      if (kind) press_hold = {cap_bytes[6], cap_bytes[5], cap_bytes[4], cap_bytes[3]};
      else temp_hold = {cap_bytes[3], cap_bytes[4]};
      held_kind = kind;
      held_valid = 1'b1;
      good_count = good_count + 32'd1;
    end
    hunt_on = 1'b0;
    cap_count = '0;
    part_sum = '0;
    made = 1'b1;
    r = '{st, held_kind, held_valid, temp_hold, press_hold, good_count};
  endtask

  task automatic log_mismatch(input string what, input reply_t want, input reply_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"%0t %s: expected st=%0d kind=%0d vv=%0d temp=%h press=%h cnt=%0d,",
                " got st=%0d kind=%0d vv=%0d temp=%h press=%h cnt=%0d"},
               $time, what, want.status, want.kind, want.value_ok, want.temp, want.press,
               want.count, got.status, got.kind, got.value_ok, got.temp, got.press, got.count);
  endtask

  task automatic add_byte(input logic [1:0] cmd, input logic [7:0] b, input logic is_last);
    stim_q.push_back('{cmd, b, is_last, 1'b0, NO_REPLY});
    if (cmd != CMD_UNUSED) random_fed++;
  endtask

  // one received buffer: mostly well-formed frames with random content, some corrupted,
  // truncated or padded, the rest noise, clears and unused commands
  task automatic add_buffer();
    int         mode;
    int         n;
    int         i;
    logic [1:0] tag;
    logic [1:0] t;
    logic [7:0] s;
    logic [7:0] fb [$];
    logic [7:0] body [$];
    bit         mixed;
    bit         lastb;
    mode = $urandom_range(0, 99);
    if (mode < 4) begin
      add_byte(srfp_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom_range(0, 1)));
      return;
    end
    if (mode < 7) begin
      add_byte(CMD_UNUSED, 8'($urandom), 1'($urandom_range(0, 1)));
      return;
    end
    tag = $urandom_range(0, 1) ? srfp_pkg::CMD_PRESS : srfp_pkg::CMD_TEMP;
    if (mode < 85) begin
      fb.push_back(srfp_pkg::FRAME_HEADER);
      if (tag == srfp_pkg::CMD_PRESS) begin
        fb.push_back(srfp_pkg::PRESS_FRAME_LEN);
        fb.push_back(srfp_pkg::PRESS_TYPE_CODE);
        repeat (4) fb.push_back(8'($urandom));
      end else begin
        fb.push_back(srfp_pkg::TEMP_FRAME_LEN);
        fb.push_back(srfp_pkg::TEMP_TYPE_CODE);
        // a zero temperature now and then, so that pressure gets refused again
        if ($urandom_range(0, 9) == 0) begin
          fb.push_back(8'h00);
          fb.push_back(8'h00);
        end else begin
          repeat (2) fb.push_back(8'($urandom));
        end
      end
      s = '0;
      foreach (fb[k]) s = s + fb[k];
      fb.push_back(s);
      if ($urandom_range(0, 5) == 0)
        fb[$urandom_range(0, fb.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, fb.size() - 1);
        repeat (n) void'(fb.pop_back());
      end
      if ($urandom_range(0, 9) == 0)
        tag = (tag == srfp_pkg::CMD_TEMP) ? srfp_pkg::CMD_PRESS : srfp_pkg::CMD_TEMP;
    end else begin
      n = $urandom_range(1, 12);
      repeat (n)
        fb.push_back(($urandom_range(0, 5) == 0) ? srfp_pkg::FRAME_HEADER : 8'($urandom));
    end

    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) body.push_back(8'($urandom));
    end
    foreach (fb[k]) body.push_back(fb[k]);
    if ($urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) body.push_back(8'($urandom));
    end

    mixed = ($urandom_range(0, 7) == 0);
    for (i = 0; i < body.size(); i++) begin
      lastb = (i == body.size() - 1);
      t = (mixed && !lastb) ?
          ($urandom_range(0, 1) ? srfp_pkg::CMD_PRESS : srfp_pkg::CMD_TEMP) : tag;
      if ($urandom_range(0, 39) == 0)
        add_byte(CMD_UNUSED, 8'($urandom), 1'($urandom_range(0, 1)));
      if (!lastb && $urandom_range(0, 149) == 0)
        add_byte(srfp_pkg::CMD_CLEAR, 8'($urandom), 1'b0);
      add_byte(t, body[i], lastb);
    end
  endtask

  // sender: bursts of random length, random gaps, now and then a long unbroken stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) send_idx++;
      if (gap_left > 0 || send_idx >= stim_q.size()) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_valid <= 1'b1;
        in_command <= stim_q[send_idx].cmd;
        in_data_byte <= stim_q[send_idx].data;
        in_last_byte <= stim_q[send_idx].is_last;
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 4) == 0) begin
          burst_left = $urandom_range(30, 80);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(0, 9);
          gap_left = $urandom_range(1, 5);
        end
      end
    end
  end

  // receiver stall pattern: free, light, heavy and long runs, switching every so often
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_run = $urandom_range(20, 120);
      end else begin
        stall_run--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_run[3];
      endcase
    end
  end

  always @(posedge clk) begin
    bit     made;
    reply_t r;
    reply_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_reply(in_command, in_data_byte, in_last_byte, made, r);
        if (made) reply_q.push_back(stim_q[took_idx].typed ? stim_q[took_idx].want : r);
        took_idx++;
      end
      if (out_valid && !out_stall) begin
        got = '{out_status, out_reply_kind, out_value_valid, out_temperature_tenths,
                out_pressure_raw, out_good_frames};
        if (reply_q.size() == 0) log_mismatch("unexpected result", 'x, got);
        else begin
          r = reply_q.pop_front();
          if (got !== r) log_mismatch("result mismatch", r, got);
        end
      end
    end
  end

  initial begin
    int waited;
    dir_rows = '{
      '{srfp_pkg::CMD_PRESS,  8'hAA, 1'b1, 1'b1,
        '{srfp_pkg::ST_NOTEMP, 1'b0, 1'b0, 16'h0000, 32'h0, 32'd0}},
      '{srfp_pkg::CMD_TEMP,   8'h55, 1'b1, 1'b1,
        '{srfp_pkg::ST_SHORT, 1'b0, 1'b0, 16'h0000, 32'h0, 32'd0}},
      '{CMD_UNUSED,           8'hFF, 1'b1, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_TEMP,   8'hFF, 1'b0, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_TEMP,   8'hAA, 1'b0, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_TEMP,   8'h06, 1'b0, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_TEMP,   8'h0A, 1'b0, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_TEMP,   8'h12, 1'b0, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_TEMP,   8'h34, 1'b0, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_TEMP,   8'h00, 1'b1, 1'b1,
        '{srfp_pkg::ST_OK, 1'b0, 1'b1, 16'h1234, 32'h0, 32'd1}},
      '{srfp_pkg::CMD_PRESS,  8'hAA, 1'b0, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_PRESS,  8'h08, 1'b0, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_PRESS,  8'h09, 1'b0, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_PRESS,  8'hFF, 1'b0, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_PRESS,  8'h00, 1'b0, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_PRESS,  8'h80, 1'b0, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_PRESS,  8'h01, 1'b0, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_PRESS,  8'h3B, 1'b1, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_CLEAR,  8'h00, 1'b1, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_PRESS,  8'hAA, 1'b1, 1'b1,
        '{srfp_pkg::ST_NOTEMP, 1'b0, 1'b0, 16'h0000, 32'h0, 32'd2}},
      '{srfp_pkg::CMD_TEMP,   8'hAA, 1'b0, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_TEMP,   8'h06, 1'b0, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_TEMP,   8'h0B, 1'b0, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_TEMP,   8'h00, 1'b0, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_TEMP,   8'h00, 1'b0, 1'b0, NO_REPLY},
      '{srfp_pkg::CMD_TEMP,   8'h00, 1'b1, 1'b1,
        '{srfp_pkg::ST_BADFIELD, 1'b0, 1'b0, 16'h0000, 32'h0, 32'd2}}
    };
    foreach (dir_rows[i]) stim_q.push_back(dir_rows[i]);
    random_fed = 0;
    while (random_fed < RANDOM_ITEMS) add_buffer();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (took_idx == stim_q.size());
    waited = 0;
    while (reply_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    while (reply_q.size() != 0) log_mismatch("missing result", reply_q.pop_front(), 'x);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
